// ===== rtl/stq_pkg.sv =====
// Types, codes and deadline compare helpers for the sorted timer queue.
package stq_pkg;

  localparam int unsigned ID_W     = 4;
  localparam int unsigned TIME_W   = 16;
  localparam int unsigned NUM_IDS  = 1 << ID_W;
  localparam int unsigned MAX_FIRE = 16;
  localparam int unsigned FIRE_W   = 5;

  typedef enum logic [1:0] {
    REQ_TICK      = 2'd0,
    REQ_SCHED_ABS = 2'd1,
    REQ_SCHED_DLY = 2'd2,
    REQ_DESCHED   = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COUNT,
    ST_POP,
    ST_ACK
  } state_e;

  typedef struct packed {
    req_e              req_type;
    logic [ID_W-1:0]   timer_id;
    logic [TIME_W-1:0] time_value;
  } stq_in_t;

  typedef struct packed {
    logic              fired;
    logic [ID_W-1:0]   expired_id;
    logic [TIME_W-1:0] current_time;
    logic              last;
  } stq_out_t;

  // one queue slot: timer number and its deadline
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] dl;
  } entry_t;

  function automatic logic is_before(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
    logic [TIME_W-1:0] diff;
    diff = a - b;
    return diff[TIME_W-1];
  endfunction

  function automatic logic is_before_eq(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
    return (a == b) || is_before(a, b);
  endfunction

endpackage

// ===== rtl/sorted_timer_queue.sv =====
// Sorted timer queue: deadline-ordered queue held in one synchronous memory.
//
//   channel | dir | handshake                 | word
//   --------+-----+---------------------------+-----------------------------
//   in      | in  | in_valid_i / in_stall_o   | in_word_i  (stq_in_t)
//   out     | out | out_valid_o / out_stall_i | out_word_o (stq_out_t)
//
// One request at a time. The queue memory is walked one entry per cycle on
// its single read port, unless an output stall holds it. A schedule or
// deschedule walks the whole queue; a deschedule of a timer that is not
// pending is acked without a walk; a tick counts the timers due, then walks
// the queue again if any are due, else acks (with no count on an empty queue).
// Reset empties the queue and clears the tick count; no clearing pass.
// Output stalls hold the walk while expiry words are emitted and hold the ack.
module sorted_timer_queue
  import stq_pkg::*;
#(
  parameter int unsigned NUM_TIMERS = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  stq_in_t  in_word_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output stq_out_t out_word_o
);

  localparam int unsigned QA_W  = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int unsigned LEN_W = $clog2(NUM_TIMERS + 1);

  state_e              state_q, state_d;
  logic [TIME_W-1:0]   now_q, now_d;
  logic [LEN_W-1:0]    len_q, len_d;
  logic [NUM_IDS-1:0]  pend_q, pend_d;
  logic [LEN_W-1:0]    k_q, k_d;
  logic [LEN_W-1:0]    w_q, w_d;
  logic [FIRE_W-1:0]   cnt_q, cnt_d;
  logic                ins_done_q, ins_done_d;
  logic                kept_q, kept_d;
  logic                carry_v_q, carry_v_d;
  entry_t              carry_q, carry_d;
  entry_t              new_q, new_d;
  logic                out_valid_q, out_valid_d;
  stq_out_t            out_q, out_d;

  entry_t              queue_mem [NUM_TIMERS];
  entry_t              rd_q;
  logic                mem_we;
  logic [QA_W-1:0]     mem_waddr;
  entry_t              mem_wdata;
  logic                rd_en;
  logic [QA_W-1:0]     rd_addr;

  logic                out_free;
  logic                emit;
  stq_out_t            emit_word;
  logic [LEN_W-1:0]    k_nxt;
  logic                k_more;
  logic [LEN_W-1:0]    cnt_len;
  logic                ins_here;
  logic                id_ok;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  assign out_free = !out_valid_q || !out_stall_i;
  assign k_nxt    = k_q + LEN_W'(1);
  assign k_more   = (k_nxt < len_q);
  assign cnt_len  = LEN_W'(cnt_q);
  assign id_ok    = int'(in_word_i.timer_id) < int'(NUM_TIMERS);
  // first kept entry uses strict compare, the rest keep equal deadlines ahead
  assign ins_here = kept_q ? !is_before_eq(rd_q.dl, new_q.dl)
                           : is_before(new_q.dl, rd_q.dl);

  always_comb begin
    state_d     = state_q;
    now_d       = now_q;
    len_d       = len_q;
    pend_d      = pend_q;
    k_d         = k_q;
    w_d         = w_q;
    cnt_d       = cnt_q;
    ins_done_d  = ins_done_q;
    kept_d      = kept_q;
    carry_v_d   = carry_v_q;
    carry_d     = carry_q;
    new_d       = new_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    mem_we      = 1'b0;
    mem_waddr   = w_q[QA_W-1:0];
    mem_wdata   = new_q;
    rd_en       = 1'b0;
    rd_addr     = k_nxt[QA_W-1:0];
    emit        = 1'b0;
    emit_word   = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          k_d       = '0;
          w_d       = '0;
          cnt_d     = '0;
          kept_d    = 1'b0;
          carry_v_d = 1'b0;
          rd_en     = 1'b1;
          rd_addr   = '0;
          new_d.id  = in_word_i.timer_id;
          new_d.dl  = (in_word_i.req_type == REQ_SCHED_ABS) ? in_word_i.time_value
                                                             : now_q + in_word_i.time_value;
          if (in_word_i.req_type == REQ_TICK) begin
            now_d   = now_q + 16'd1;
            state_d = (len_q == '0) ? ST_ACK : ST_COUNT;
          end else if (!id_ok) begin
            state_d = ST_ACK;
          end else if (in_word_i.req_type == REQ_DESCHED) begin
            if (pend_q[in_word_i.timer_id]) begin
              ins_done_d                   = 1'b1;
              pend_d[in_word_i.timer_id] = 1'b0;
              state_d                      = ST_SCAN;
            end else begin
              state_d = ST_ACK;
            end
          end else if (!pend_q[in_word_i.timer_id] && len_q == LEN_W'(NUM_TIMERS)) begin
            state_d = ST_ACK;
          end else begin
            ins_done_d                   = 1'b0;
            pend_d[in_word_i.timer_id] = 1'b1;
            state_d                      = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        if (k_q < len_q) begin
          rd_en = k_more;
          k_d   = k_nxt;
          if (rd_q.id == new_q.id) begin
            // old instance of this timer: dropped
          end else if (!ins_done_q && ins_here) begin
            mem_we     = 1'b1;
            mem_wdata  = new_q;
            w_d        = w_q + LEN_W'(1);
            carry_d    = rd_q;
            carry_v_d  = 1'b1;
            ins_done_d = 1'b1;
            kept_d     = 1'b1;
          end else begin
            mem_we    = 1'b1;
            mem_wdata = carry_v_q ? carry_q : rd_q;
            if (carry_v_q) begin
              carry_d = rd_q;
            end
            w_d    = w_q + LEN_W'(1);
            kept_d = 1'b1;
          end
        end else begin
          if (carry_v_q) begin
            mem_we    = 1'b1;
            mem_wdata = carry_q;
          end else if (!ins_done_q) begin
            mem_we    = 1'b1;
            mem_wdata = new_q;
          end
          len_d   = (carry_v_q || !ins_done_q) ? w_q + LEN_W'(1) : w_q;
          state_d = ST_ACK;
        end
      end

      ST_COUNT: begin
        if (k_q < len_q && cnt_q < FIRE_W'(MAX_FIRE) && is_before_eq(rd_q.dl, now_q)) begin
          cnt_d = cnt_q + FIRE_W'(1);
          k_d   = k_nxt;
          rd_en = k_more;
        end else if (cnt_q == '0) begin
          state_d = ST_ACK;
        end else begin
          k_d     = '0;
          rd_en   = 1'b1;
          rd_addr = '0;
          state_d = ST_POP;
        end
      end

      ST_POP: begin
        if (k_q < cnt_len) begin
          if (out_free) begin
            emit                   = 1'b1;
            emit_word.fired        = 1'b1;
            emit_word.expired_id   = rd_q.id;
            emit_word.current_time = now_q;
            emit_word.last         = (k_nxt == cnt_len);
            pend_d[rd_q.id]        = 1'b0;
            k_d                    = k_nxt;
            rd_en                  = k_more;
          end
        end else if (k_q < len_q) begin
          mem_we    = 1'b1;
          mem_waddr = QA_W'(k_q - cnt_len);
          mem_wdata = rd_q;
          k_d       = k_nxt;
          rd_en     = k_more;
        end else begin
          len_d   = len_q - cnt_len;
          state_d = ST_IDLE;
        end
      end

      ST_ACK: begin
        if (out_free) begin
          emit                   = 1'b1;
          emit_word.current_time = now_q;
          emit_word.last         = 1'b1;
          state_d                = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (emit) begin
      out_valid_d = 1'b1;
      out_d       = emit_word;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      now_q       <= '0;
      len_q       <= '0;
      pend_q      <= '0;
      k_q         <= '0;
      w_q         <= '0;
      cnt_q       <= '0;
      ins_done_q  <= 1'b0;
      kept_q      <= 1'b0;
      carry_v_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      now_q       <= now_d;
      len_q       <= len_d;
      pend_q      <= pend_d;
      k_q         <= k_d;
      w_q         <= w_d;
      cnt_q       <= cnt_d;
      ins_done_q  <= ins_done_d;
      kept_q      <= kept_d;
      carry_v_q   <= carry_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    carry_q <= carry_d;
    new_q   <= new_d;
    out_q   <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      queue_mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_q <= queue_mem[rd_addr];
    end
  end

`ifndef SYNTH
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(len_q) <= int'(NUM_TIMERS))
    else $error("queue length beyond capacity");

  a_pend_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> $countones(pend_q) == int'(len_q))
    else $error("pending flags disagree with queue length");

  a_tick_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_word_i.req_type == REQ_TICK
      |=> now_q == $past(now_q) + 16'd1)
    else $error("tick count did not advance");

  a_pop_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_POP |-> int'(cnt_q) <= int'(len_q) && cnt_q != '0)
    else $error("fire count out of range");
`endif

endmodule

// ===== bench/tb.sv =====
// Testbench for sorted_timer_queue: directed table, all-timers-due burst, then random traffic against a predictor.
module tb;
  import stq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEMS        = 320;
  localparam int HOLD_CYCLES  = 300;
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 64;
  localparam int DIR_N        = 19;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  stq_in_t  in_word_i;
  logic     out_valid_o;
  logic     out_stall_i;
  stq_out_t out_word_o;

  sorted_timer_queue dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  // directed rows; lit rows carry a single ack/idle-tick word at time 'at'
  typedef struct {
    req_e              req;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] tv;
    bit                lit;
    logic [TIME_W-1:0] at;
  } dir_row_t;

  dir_row_t dir_rows [DIR_N] = '{
    '{REQ_TICK,      4'd0,  16'h0000, 1'b1, 16'd1},
    '{REQ_SCHED_ABS, 4'd15, 16'hFFFF, 1'b1, 16'd1},
    '{REQ_SCHED_DLY, 4'd0,  16'h0000, 1'b1, 16'd1},
    '{REQ_DESCHED,   4'd7,  16'h0000, 1'b1, 16'd1},
    '{REQ_SCHED_ABS, 4'd3,  16'h0002, 1'b1, 16'd1},
    '{REQ_SCHED_ABS, 4'd4,  16'h0002, 1'b1, 16'd1},
    '{REQ_SCHED_DLY, 4'd5,  16'hFFFF, 1'b1, 16'd1},
    '{REQ_SCHED_ABS, 4'd3,  16'h0002, 1'b1, 16'd1},
    '{REQ_DESCHED,   4'd4,  16'h0000, 1'b1, 16'd1},
    '{REQ_TICK,      4'd0,  16'h0000, 1'b0, 16'd0},
    '{REQ_TICK,      4'd9,  16'hA5A5, 1'b0, 16'd0},
    '{REQ_SCHED_DLY, 4'd8,  16'h8000, 1'b1, 16'd3},
    '{REQ_SCHED_ABS, 4'd9,  16'h8002, 1'b1, 16'd3},
    '{REQ_SCHED_DLY, 4'd10, 16'h7FFF, 1'b1, 16'd3},
    '{REQ_SCHED_ABS, 4'd11, 16'h0003, 1'b1, 16'd3},
    '{REQ_TICK,      4'd15, 16'hFFFF, 1'b0, 16'd0},
    '{REQ_DESCHED,   4'd15, 16'hFFFF, 1'b1, 16'd4},
    '{REQ_DESCHED,   4'd0,  16'h0000, 1'b1, 16'd4},
    '{REQ_TICK,      4'd0,  16'h0000, 1'b0, 16'd0}
  };

  // predictor state
  logic [TIME_W-1:0] tick_now;
  logic [TIME_W-1:0] deadline_of [NUM_IDS];
  bit                armed [NUM_IDS];
  logic [ID_W-1:0]   timer_order [$];
  stq_out_t          step_words [$];
  stq_out_t          queued_replies [$];

  int  mismatches;
  int  sent;
  int  quiet;
  bit  idle_en;
  bit  hold_pending;
  bit  hold_done;
  stq_out_t want_now;

  function automatic bit wrap_before(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
    logic [TIME_W-1:0] d;
    d = a - b;
    return d[TIME_W-1];
  endfunction

  function automatic bit wrap_before_eq(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
    return (a == b) || wrap_before(a, b);
  endfunction

  function automatic void drop_timer(logic [ID_W-1:0] id);
    int i;
    if (!armed[id]) return;
    for (i = 0; i < timer_order.size(); i++) begin
      if (timer_order[i] == id) begin
        timer_order.delete(i);
        break;
      end
    end
    armed[id] = 1'b0;
  endfunction

  function automatic void place_timer(logic [ID_W-1:0] id);
    int pos;
    pos = 0;
    if (timer_order.size() != 0 && !wrap_before(deadline_of[id], deadline_of[timer_order[0]]))
    begin
      pos = 1;
      while (pos < timer_order.size() &&
             wrap_before_eq(deadline_of[timer_order[pos]], deadline_of[id]))
        pos++;
    end
    timer_order.insert(pos, id);
    armed[id] = 1'b1;
  endfunction

  // advance the timer set by one request, leaving its output words in step_words
  function automatic void advance_timers(stq_in_t w);
    int n;
    logic [ID_W-1:0] head;
    stq_out_t o;
    step_words.delete();
    if (w.req_type == REQ_TICK) begin
      tick_now = tick_now + 16'd1;
      n = 0;
      while (n < MAX_FIRE && timer_order.size() > 0) begin
        head = timer_order[0];
        if (!wrap_before_eq(deadline_of[head], tick_now)) break;
        drop_timer(head);
        o = '{fired: 1'b1, expired_id: head, current_time: tick_now, last: 1'b0};
        step_words.push_back(o);
        n++;
      end
      if (n == 0) begin
        o = '{fired: 1'b0, expired_id: '0, current_time: tick_now, last: 1'b1};
        step_words.push_back(o);
      end else begin
        step_words[n-1].last = 1'b1;
      end
    end else begin
      if (w.req_type == REQ_DESCHED) begin
        drop_timer(w.timer_id);
      end else begin
        deadline_of[w.timer_id] = (w.req_type == REQ_SCHED_ABS) ? w.time_value
                                                                : tick_now + w.time_value;
        drop_timer(w.timer_id);
        place_timer(w.timer_id);
      end
      o = '{fired: 1'b0, expired_id: '0, current_time: tick_now, last: 1'b1};
      step_words.push_back(o);
    end
  endfunction

  task automatic note_mismatch(string what, int got, int want);
    $display("tb: %s: got %0h, expected %0h at %0t", what, got, want, $time);
    mismatches++;
  endtask

  // called just after a rising edge; returns at the edge that accepts the word
  task automatic send_req(stq_in_t w, bit lit, logic [TIME_W-1:0] at);
    stq_out_t o;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    advance_timers(w);
    if (lit) begin
      o = '{fired: 1'b0, expired_id: '0, current_time: at, last: 1'b1};
      queued_replies.push_back(o);
    end else begin
      foreach (step_words[i]) queued_replies.push_back(step_words[i]);
    end
    sent++;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // receiver: random stall bursts, plus one long hold-off
  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (queued_replies.size() == 0) begin
        note_mismatch("unexpected word", out_word_o, 0);
      end else begin
        want_now = queued_replies.pop_front();
        if (out_word_o.fired !== want_now.fired)
          note_mismatch("fired", out_word_o.fired, want_now.fired);
        if (out_word_o.expired_id !== want_now.expired_id)
          note_mismatch("expired_id", out_word_o.expired_id, want_now.expired_id);
        if (out_word_o.current_time !== want_now.current_time)
          note_mismatch("current_time", out_word_o.current_time, want_now.current_time);
        if (out_word_o.last !== want_now.last)
          note_mismatch("last", out_word_o.last, want_now.last);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    stq_in_t w;
    int pick;
    mismatches   = 0;
    sent         = 0;
    idle_en      = 1'b1;
    hold_pending = 1'b0;
    hold_done    = 1'b0;
    tick_now     = '0;
    foreach (armed[i]) armed[i] = 1'b0;
    foreach (deadline_of[i]) deadline_of[i] = '0;
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_word_i  <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[r]) begin
      w.req_type   = dir_rows[r].req;
      w.timer_id   = dir_rows[r].id;
      w.time_value = dir_rows[r].tv;
      send_req(w, dir_rows[r].lit, dir_rows[r].at);
    end

    // every timer due on the same tick
    for (int i = 0; i < NUM_IDS; i++) begin
      w.req_type   = REQ_SCHED_DLY;
      w.timer_id   = ID_W'(i);
      w.time_value = 16'd2;
      send_req(w, 1'b0, '0);
    end
    repeat (2) begin
      w.req_type   = REQ_TICK;
      w.timer_id   = ID_W'($urandom_range(0, 15));
      w.time_value = TIME_W'($urandom_range(0, 65535));
      send_req(w, 1'b0, '0);
    end

    while (sent < ITEMS) begin
      idle_en = (sent < 150) || (sent >= 200 && sent < 260);
      if (!hold_done && sent >= 100) begin
        hold_pending = 1'b1;
        hold_done    = 1'b1;
      end
      pick = $urandom_range(0, 9);
      if (pick <= 5) begin
        repeat ($urandom_range(1, 6)) begin
          w.timer_id = ID_W'($urandom_range(0, 15));
          case ($urandom_range(0, 3))
            0, 1: begin
              w.req_type   = REQ_SCHED_DLY;
              w.time_value = TIME_W'($urandom_range(0, 12));
            end
            2: begin
              w.req_type   = REQ_SCHED_ABS;
              w.time_value = tick_now + TIME_W'($urandom_range(0, 12));
            end
            default: begin
              w.req_type   = $urandom_range(0, 1) ? REQ_SCHED_ABS : REQ_SCHED_DLY;
              w.time_value = TIME_W'($urandom_range(0, 65535));
            end
          endcase
          send_req(w, 1'b0, '0);
          if ($urandom_range(0, 4) == 0) begin
            w.req_type   = REQ_DESCHED;
            w.timer_id   = ID_W'($urandom_range(0, 15));
            w.time_value = TIME_W'($urandom_range(0, 65535));
            send_req(w, 1'b0, '0);
          end
        end
        repeat ($urandom_range(1, 10)) begin
          w.req_type   = REQ_TICK;
          w.timer_id   = ID_W'($urandom_range(0, 15));
          w.time_value = TIME_W'($urandom_range(0, 65535));
          send_req(w, 1'b0, '0);
        end
      end else if (pick <= 7) begin
        w.req_type   = REQ_DESCHED;
        w.timer_id   = ID_W'($urandom_range(0, 15));
        w.time_value = TIME_W'($urandom_range(0, 65535));
        send_req(w, 1'b0, '0);
      end else if (pick == 8) begin
        repeat ($urandom_range(1, 15)) begin
          w.req_type   = REQ_TICK;
          w.timer_id   = ID_W'($urandom_range(0, 15));
          w.time_value = TIME_W'($urandom_range(0, 65535));
          send_req(w, 1'b0, '0);
        end
      end else begin
        w.req_type   = req_e'($urandom_range(0, 3));
        w.timer_id   = ID_W'($urandom_range(0, 15));
        w.time_value = TIME_W'($urandom_range(0, 65535));
        send_req(w, 1'b0, '0);
      end
    end

    in_valid_i <= 1'b0;
    while (queued_replies.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
